>>> sv/mrrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrrd_pkg: shared types and codes
// Holds the operation codes, the field widths and the command kinds that pass
// from the front part to the back part through the queue.
// ----------------------------------------------------------------------------
package mrrd_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam int unsigned FIELD_W   = 16;
    localparam int unsigned ID_W      = 7;
    localparam int unsigned RANK_W    = 7;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

endpackage
`default_nettype wire

>>> sv/min_reduce_then_rank_descending.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_reduce_then_rank_descending: per-node minimum and stable ranked list
// Front part, command queue and sorted list engine.
// ----------------------------------------------------------------------------
// A load word folds its dependency into the running minimum and,
// when it closes a node, hands the node id and minimum to the list engine.
// The list sits in one single-port-read memory kept in descending order of
// minimum, ties in arrival order. An insert walks the list one entry a cycle
// to find its place, shifts the tail one entry a cycle when it lands inside
// the list and then writes the new entry; a read of a stored entry passes a
// wait state and an output state, and every read returns one word, with
// none_left set when the read pointer has passed the end. Load words that do
// not close a node never wait on the engine unless the queue of two commands
// is full. A clear empties the list. Nodes closed while the list already
// holds KEY_CAPACITY entries are dropped.
// ----------------------------------------------------------------------------
module min_reduce_then_rank_descending #(
    parameter int unsigned KEY_CAPACITY = 128,
    parameter int unsigned DEP_WIDTH    = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [6:0]  node_id,
    input  wire logic [15:0] dependency,
    input  wire logic        end_of_node,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [6:0]       rank,
    output logic [6:0]       ranked_node,
    output logic [15:0]      min_dependency,
    output logic             last_entry,
    output logic             none_left
);

    localparam int unsigned QW = 2 + mrrd_pkg::ID_W + DEP_WIDTH;

    logic                        f_valid, f_stall;
    mrrd_pkg::cmd_t              f_kind;
    logic [mrrd_pkg::ID_W-1:0]   f_id;
    logic [DEP_WIDTH-1:0]        f_min;
    logic                        b_valid, b_stall;
    logic [QW-1:0]               q_out;

    mrrd_front #(.DEP_WIDTH(DEP_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .node_id(node_id), .dependency(dependency),
        .end_of_node(end_of_node),
        .cmd_valid(f_valid), .cmd_stall(f_stall),
        .cmd_kind(f_kind), .cmd_id(f_id), .cmd_min(f_min)
    );

    mrrd_queue #(.WIDTH(QW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_stall(f_stall),
        .wr_data({f_kind, f_id, f_min}),
        .rd_valid(b_valid), .rd_stall(b_stall),
        .rd_data(q_out)
    );

    mrrd_back #(.KEY_CAPACITY(KEY_CAPACITY), .DEP_WIDTH(DEP_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(b_valid), .cmd_stall(b_stall),
        .cmd_kind(mrrd_pkg::cmd_t'(q_out[QW-1 -: 2])),
        .cmd_id(q_out[DEP_WIDTH +: mrrd_pkg::ID_W]),
        .cmd_min(q_out[DEP_WIDTH-1:0]),
        .out_valid(out_valid), .out_stall(out_stall),
        .rank(rank), .ranked_node(ranked_node),
        .min_dependency(min_dependency),
        .last_entry(last_entry), .none_left(none_left)
    );

endmodule
`default_nettype wire

>>> sv/mrrd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrrd_front: input classifier and running minimum
// Folds load words into the running minimum and issues insert, read and
// clear commands into the queue toward the back part.
// ----------------------------------------------------------------------------
module mrrd_front #(
    parameter int unsigned DEP_WIDTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  op,
    input  wire logic [mrrd_pkg::ID_W-1:0]   node_id,
    input  wire logic [mrrd_pkg::FIELD_W-1:0] dependency,
    input  wire logic                        end_of_node,
    output logic                             cmd_valid,
    input  wire logic                        cmd_stall,
    output mrrd_pkg::cmd_t                   cmd_kind,
    output logic [mrrd_pkg::ID_W-1:0]        cmd_id,
    output logic [DEP_WIDTH-1:0]             cmd_min
);

    logic [DEP_WIDTH-1:0] run_min_reg, run_min_next;
    logic [DEP_WIDTH-1:0] dep_low, fold_min;
    logic                 accept;
    logic                 emit;

    assign dep_low  = DEP_WIDTH'(dependency);
    assign fold_min = (dep_low < run_min_reg) ? dep_low : run_min_reg;
    assign in_stall = cmd_stall;
    assign accept   = in_valid && !cmd_stall;

    // Loads without end of node emit nothing; unused code is dropped.
    always_comb
    begin
        emit     = 1'b0;
        cmd_kind = mrrd_pkg::CMD_READ;
        case (op)
            mrrd_pkg::OP_LOAD:
            begin
                emit     = end_of_node;
                cmd_kind = mrrd_pkg::CMD_INSERT;
            end
            mrrd_pkg::OP_READ:
            begin
                emit     = 1'b1;
                cmd_kind = mrrd_pkg::CMD_READ;
            end
            mrrd_pkg::OP_CLEAR:
            begin
                emit     = 1'b1;
                cmd_kind = mrrd_pkg::CMD_CLEAR;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign cmd_valid = in_valid && emit;
    assign cmd_id    = node_id;
    assign cmd_min   = fold_min;

    always_comb
    begin
        run_min_next = run_min_reg;
        if (accept && op == mrrd_pkg::OP_LOAD)
        begin
            run_min_next = end_of_node ? {DEP_WIDTH{1'b1}} : fold_min;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_reg <= {DEP_WIDTH{1'b1}};
        end
        else
        begin
            run_min_reg <= run_min_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/mrrd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrrd_queue: two-entry command queue
// Decouples the front part from the back part.
// ----------------------------------------------------------------------------
module mrrd_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_stall,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_stall,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr, do_rd;

    assign wr_stall = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !wr_stall;
    assign do_rd    = rd_valid && !rd_stall;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !do_rd) |=> count_reg == 2'd2)
        else $error("queue lost an entry while full");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> !do_rd)
        else $error("queue read while empty");

endmodule
`default_nettype wire

>>> sv/mrrd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrrd_back: sorted list engine
// Inserts by a search then a shift over the list memory, one entry a cycle,
// and serves reads from the memory through a registered output.
// ----------------------------------------------------------------------------
module mrrd_back #(
    parameter int unsigned KEY_CAPACITY = 128,
    parameter int unsigned DEP_WIDTH    = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_stall,
    input  wire mrrd_pkg::cmd_t                cmd_kind,
    input  wire logic [mrrd_pkg::ID_W-1:0]     cmd_id,
    input  wire logic [DEP_WIDTH-1:0]          cmd_min,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mrrd_pkg::RANK_W-1:0]        rank,
    output logic [mrrd_pkg::ID_W-1:0]          ranked_node,
    output logic [mrrd_pkg::FIELD_W-1:0]       min_dependency,
    output logic                               last_entry,
    output logic                               none_left
);

    localparam int unsigned AW = (KEY_CAPACITY > 1) ? $clog2(KEY_CAPACITY) : 1;
    localparam int unsigned CW = $clog2(KEY_CAPACITY + 1);
    localparam int unsigned EW = DEP_WIDTH + mrrd_pkg::ID_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_SHIFT  = 6'b000100,
        ST_PLACE  = 6'b001000,
        ST_RDWAIT = 6'b010000,
        ST_RDOUT  = 6'b100000
    } state_t;

    logic [EW-1:0] mem [KEY_CAPACITY];
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] k_reg, k_next;
    logic [EW-1:0] new_reg, new_next;
    logic [EW-1:0] res_reg, res_next;
    logic [CW-1:0] res_rank_reg, res_rank_next;
    logic          res_last_reg, res_last_next;
    logic          res_none_reg, res_none_next;
    logic          ov_reg, ov_next;
    logic          take;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] k_m2;

    assign cnt_m1 = count_reg - CW'(1);
    assign k_m2   = k_reg - CW'(2);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign take      = cmd_valid && !cmd_stall;
    assign cmd_stall = !(state_reg == ST_IDLE) || (ov_reg && out_stall);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rptr_next     = rptr_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        new_next      = new_reg;
        res_next      = res_reg;
        res_rank_next = res_rank_reg;
        res_last_next = res_last_reg;
        res_none_next = res_none_reg;
        ov_next       = ov_reg && out_stall;
        rd_addr       = pos_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = k_reg[AW-1:0];
        wr_data       = rd_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (cmd_kind)
                        mrrd_pkg::CMD_INSERT:
                        begin
                            new_next = {cmd_min, cmd_id};
                            pos_next = '0;
                            rd_addr  = '0;
                            if (count_reg < CW'(KEY_CAPACITY))
                            begin
                                state_next = (count_reg == '0) ? ST_PLACE : ST_SEARCH;
                            end
                        end
                        mrrd_pkg::CMD_READ:
                        begin
                            if (rptr_reg < count_reg)
                            begin
                                rd_addr    = rptr_reg[AW-1:0];
                                state_next = ST_RDWAIT;
                            end
                            else
                            begin
                                res_next      = '0;
                                res_rank_next = '0;
                                res_last_next = 1'b0;
                                res_none_next = 1'b1;
                                ov_next       = 1'b1;
                            end
                        end
                        mrrd_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            rptr_next  = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                // rd_data_reg holds entry pos_reg.
                if (rd_data_reg[EW-1:mrrd_pkg::ID_W] >= new_reg[EW-1:mrrd_pkg::ID_W])
                begin
                    pos_next = pos_reg + CW'(1);
                    rd_addr  = pos_next[AW-1:0];
                    if (pos_next == count_reg)
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    k_next     = count_reg;
                    rd_addr    = cnt_m1[AW-1:0];
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                // rd_data_reg holds entry k_reg - 1; move it up one place.
                wr_en   = 1'b1;
                wr_addr = k_reg[AW-1:0];
                wr_data = rd_data_reg;
                k_next  = k_reg - CW'(1);
                rd_addr = k_m2[AW-1:0];
                if (k_next == pos_reg)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[AW-1:0];
                wr_data    = new_reg;
                count_next = count_reg + CW'(1);
                state_next = ST_IDLE;
            end
            ST_RDWAIT:
            begin
                rd_addr    = rptr_reg[AW-1:0];
                state_next = ST_RDOUT;
            end
            ST_RDOUT:
            begin
                // Keep the entry in the read register while the output waits.
                rd_addr = rptr_reg[AW-1:0];
                if (!(ov_reg && out_stall))
                begin
                    res_next      = rd_data_reg;
                    res_rank_next = rptr_reg;
                    res_last_next = (rptr_reg + CW'(1) == count_reg);
                    res_none_next = 1'b0;
                    ov_next       = 1'b1;
                    rptr_next     = rptr_reg + CW'(1);
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        k_reg        <= k_next;
        new_reg      <= new_next;
        res_reg      <= res_next;
        res_rank_reg <= res_rank_next;
        res_last_reg <= res_last_next;
        res_none_reg <= res_none_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rptr_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rptr_reg  <= rptr_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid      = ov_reg;
    assign rank           = res_rank_reg[mrrd_pkg::RANK_W-1:0];
    assign ranked_node    = res_reg[mrrd_pkg::ID_W-1:0];
    assign min_dependency = mrrd_pkg::FIELD_W'(res_reg[EW-1:mrrd_pkg::ID_W]);
    assign last_entry     = res_last_reg;
    assign none_left      = res_none_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(KEY_CAPACITY))
        else $error("entry count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && none_left) |-> (!last_entry && rank == '0))
        else $error("past-end result carries data");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the list");

endmodule
`default_nettype wire
